// ===== hdl/crcp_pkg.sv =====
// shared constants, types and index helpers for the console ring packetizer
package crcp_pkg;

  localparam int RingDepth = 8192;
  localparam int IdxW      = $clog2(RingDepth);
  localparam int FillW     = 13;
  localparam int ThrW      = 13;
  localparam int PktW      = 14;
  localparam int ByteW     = 8;
  localparam int CmpW      = ((IdxW > PktW) ? IdxW : PktW) + 1;
  localparam int CfgIdxW   = 8;
  localparam int CfgDataW  = 16;

  localparam logic [ByteW-1:0] CharLf = 8'h0A;
  localparam logic [ByteW-1:0] CharCr = 8'h0D;

  localparam logic [ThrW-1:0] ResetThreshold = 13'd128;
  localparam logic [PktW-1:0] ResetLimit     = 14'd8192;

  typedef enum logic [CfgIdxW-1:0] {
    REG_LINE_CONNECTED = 8'd0,
    REG_LOW_ROOM_THR   = 8'd1,
    REG_CRLF_ENABLE    = 8'd2,
    REG_PACKET_LIMIT   = 8'd3
  } cfg_reg_e;

  typedef logic [IdxW-1:0] idx_t;

  typedef struct packed {
    logic             accepted;
    logic             out_valid;
    logic [ByteW-1:0] data_out;
    logic             packet_last;
    logic [FillW-1:0] fill_level;
    logic [FillW-1:0] free_room;
  } result_t;

  function automatic idx_t ring_next(input idx_t i);
    idx_t n;
    n = (i == idx_t'(RingDepth - 1)) ? '0 : i + idx_t'(1);
    return n;
  endfunction

  function automatic idx_t ring_fill(input idx_t w, input idx_t r);
    logic [IdxW:0] s;
    s = {1'b0, w} - {1'b0, r};
    if (w < r) begin
      s = s + (IdxW+1)'(RingDepth);
    end
    return s[IdxW-1:0];
  endfunction

  function automatic idx_t ring_room(input idx_t w, input idx_t r);
    idx_t f;
    f = ring_fill(w, r);
    return idx_t'(RingDepth - 1) - f;
  endfunction

endpackage

// ===== hdl/crcp_if.sv =====
// channel interfaces: byte requests in, results out, register writes
interface crcp_in_if;
  import crcp_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [ByteW-1:0] data_in;
  logic             write_start;

  modport source (output valid, mode, data_in, write_start, input ready);
  modport sink   (input valid, mode, data_in, write_start, output ready);
endinterface

interface crcp_out_if;
  import crcp_pkg::*;
  logic             valid;
  logic             ready;
  logic             accepted;
  logic             out_valid;
  logic [ByteW-1:0] data_out;
  logic             packet_last;
  logic [FillW-1:0] fill_level;
  logic [FillW-1:0] free_room;

  modport source (output valid, accepted, out_valid, data_out, packet_last, fill_level,
                  free_room, input ready);
  modport sink   (input valid, accepted, out_valid, data_out, packet_last, fill_level,
                  free_room, output ready);
endinterface

interface crcp_cfg_if;
  import crcp_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/console_ring_crlf_packetizer.sv =====
// console byte ring with lf expansion and packet marking
//
//  channel | dir | payload                                          | handshake
//  in_i    | in  | mode, data_in, write_start                       | valid/ready
//  out_o   | out | accepted, out_valid, data_out, packet_last,      | valid/ready
//          |     | fill_level, free_room                            |
//  cfg_i   | in  | index, data                                      | valid/ready
//
// a put, a pop of a pending lf and a pop of an empty ring are answered from ST_IDLE
// a pop that reads the ring passes ST_READ too, for the ring memory read port
// one request at a time; the next is taken while the last result waits in the
// output register, and out_o.ready low holds the block once that register is full
// rst_ni clears indices, packet count, pending lf and registers; ring contents
// are left as they are and never read before being written
module console_ring_crlf_packetizer
  import crcp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  crcp_in_if.sink    in_i,
  crcp_out_if.source out_o,
  crcp_cfg_if.sink   cfg_i
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e state_q, state_d;

  idx_t            wr_idx_q, wr_idx_d;
  idx_t            rd_idx_q, rd_idx_d;
  logic            lf_pend_q, lf_pend_d;
  logic [PktW-1:0] pkt_cnt_q, pkt_cnt_d;
  logic            res_vld_q, res_vld_d;
  result_t         res_q, res_d;

  logic            line_conn_q;
  logic [ThrW-1:0] low_thr_q;
  logic            crlf_en_q;
  logic [PktW-1:0] pkt_limit_q;

  logic             mem_we, mem_re;
  idx_t             mem_waddr;
  logic [ByteW-1:0] mem_rdata;

  logic            in_fire;
  logic [PktW-1:0] close_pt;
  logic [PktW-1:0] pkt_cnt_inc;
  logic [PktW-1:0] lim_adj;

  logic wipe;
  idx_t wr_base, rd_base, fill_cur;

  crcp_ring_mem u_ring (
    .clk_i    (clk_i),
    .wr_en_i  (mem_we),
    .wr_addr_i(mem_waddr),
    .wr_data_i(in_i.data_in),
    .rd_en_i  (mem_re),
    .rd_addr_i(rd_idx_q),
    .rd_data_o(mem_rdata)
  );

  // configuration writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_conn_q <= 1'b1;
      low_thr_q   <= ResetThreshold;
      crlf_en_q   <= 1'b1;
      pkt_limit_q <= ResetLimit;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_LINE_CONNECTED: line_conn_q <= cfg_i.data[0];
        REG_LOW_ROOM_THR:   low_thr_q   <= cfg_i.data[ThrW-1:0];
        REG_CRLF_ENABLE:    crlf_en_q   <= cfg_i.data[0];
        REG_PACKET_LIMIT:   pkt_limit_q <= cfg_i.data[PktW-1:0];
        default: ;
      endcase
    end
  end

  // packet close point, never below one byte
  always_comb begin
    lim_adj = pkt_limit_q;
    if (crlf_en_q) begin
      lim_adj = (pkt_limit_q > PktW'(2)) ? pkt_limit_q - PktW'(2) : '0;
    end
    close_pt = (lim_adj == '0) ? PktW'(1) : lim_adj;
  end

  assign pkt_cnt_inc = pkt_cnt_q + PktW'(1);
  assign fill_cur    = ring_fill(wr_idx_q, rd_idx_q);

  assign in_i.ready = (state_q == ST_IDLE) && (!res_vld_q || out_o.ready);
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    state_d   = state_q;
    wr_idx_d  = wr_idx_q;
    rd_idx_d  = rd_idx_q;
    lf_pend_d = lf_pend_q;
    pkt_cnt_d = pkt_cnt_q;
    res_vld_d = res_vld_q && !out_o.ready;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = wr_idx_q;

    // overwrite check on the first byte of a write while the line is down
    wipe    = in_i.write_start && !line_conn_q &&
              (CmpW'(ring_room(wr_idx_q, rd_idx_q)) < CmpW'(low_thr_q));
    wr_base = wipe ? '0 : wr_idx_q;
    rd_base = wipe ? '0 : rd_idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_d = '0;
          if (!in_i.mode) begin
            wr_idx_d = wr_base;
            rd_idx_d = rd_base;
            if (ring_room(wr_base, rd_base) != '0) begin
              mem_we         = 1'b1;
              mem_waddr      = wr_base;
              wr_idx_d       = ring_next(wr_base);
              res_d.accepted = 1'b1;
            end
            res_d.fill_level = FillW'(ring_fill(wr_idx_d, rd_idx_d));
            res_d.free_room  = FillW'(ring_room(wr_idx_d, rd_idx_d));
            res_vld_d        = 1'b1;
          end else if (lf_pend_q) begin
            lf_pend_d         = 1'b0;
            res_d.out_valid   = 1'b1;
            res_d.data_out    = CharLf;
            res_d.packet_last = (pkt_cnt_inc >= close_pt) || (fill_cur == '0);
            pkt_cnt_d         = res_d.packet_last ? '0 : pkt_cnt_inc;
            res_d.fill_level  = FillW'(fill_cur);
            res_d.free_room   = FillW'(ring_room(wr_idx_q, rd_idx_q));
            res_vld_d         = 1'b1;
          end else if (fill_cur != '0) begin
            mem_re   = 1'b1;
            rd_idx_d = ring_next(rd_idx_q);
            state_d  = ST_READ;
          end else begin
            res_d.fill_level = FillW'(fill_cur);
            res_d.free_room  = FillW'(ring_room(wr_idx_q, rd_idx_q));
            res_vld_d        = 1'b1;
          end
        end
      end
      ST_READ: begin
        // read index already advanced, so fill here is the level after the pop
        res_d            = '0;
        res_d.out_valid  = 1'b1;
        res_d.fill_level = FillW'(fill_cur);
        res_d.free_room  = FillW'(ring_room(wr_idx_q, rd_idx_q));
        if (crlf_en_q && (mem_rdata == CharLf)) begin
          res_d.data_out = CharCr;
          lf_pend_d      = 1'b1;
          pkt_cnt_d      = pkt_cnt_inc;
        end else begin
          res_d.data_out    = mem_rdata;
          res_d.packet_last = (pkt_cnt_inc >= close_pt) || (fill_cur == '0);
          pkt_cnt_d         = res_d.packet_last ? '0 : pkt_cnt_inc;
        end
        res_vld_d = 1'b1;
        state_d   = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wr_idx_q  <= '0;
      rd_idx_q  <= '0;
      lf_pend_q <= 1'b0;
      pkt_cnt_q <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_idx_q  <= wr_idx_d;
      rd_idx_q  <= rd_idx_d;
      lf_pend_q <= lf_pend_d;
      pkt_cnt_q <= pkt_cnt_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid       = res_vld_q;
  assign out_o.accepted    = res_q.accepted;
  assign out_o.out_valid   = res_q.out_valid;
  assign out_o.data_out    = res_q.data_out;
  assign out_o.packet_last = res_q.packet_last;
  assign out_o.fill_level  = res_q.fill_level;
  assign out_o.free_room   = res_q.free_room;

endmodule

// ===== hdl/crcp_ring_mem.sv =====
// byte ring storage: one write port, one registered read port
module crcp_ring_mem
  import crcp_pkg::*;
(
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  idx_t             wr_addr_i,
  input  logic [ByteW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  idx_t             rd_addr_i,
  output logic [ByteW-1:0] rd_data_o
);

  logic [ByteW-1:0] mem_q [RingDepth];
  logic [ByteW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the console byte ring with lf expansion and packet marking
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import crcp_pkg::*;

  localparam bit MODE_PUT       = 1'b0;
  localparam bit MODE_POP       = 1'b1;
  localparam int HOLD_CYCLES    = 300;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int MAX_PRINTS     = 200;
  localparam int SEG_ITEMS      = 50;
  localparam int SEGS_PER_PHASE = 5;

  typedef struct packed {
    logic             mode;
    logic [ByteW-1:0] data;
    logic             start;
  } byte_req_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  crcp_in_if  req_if ();
  crcp_out_if res_if ();
  crcp_cfg_if cfg_if ();

  console_ring_crlf_packetizer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // shadow copy of the ring and its registers
  logic [ByteW-1:0] ring_bytes [RingDepth];
  idx_t             wr_ptr;
  idx_t             rd_ptr;
  logic             lf_owed;
  logic [PktW-1:0]  pkt_bytes;
  logic             link_up;
  logic [ThrW-1:0]  low_thr;
  logic             crlf_on;
  logic [PktW-1:0]  pkt_lim;

  byte_req_t byte_reqs_q[$];
  result_t   ring_results_q[$];
  int        reqs_in_flight = 0;
  int        mismatches     = 0;
  int        cycles         = 0;
  int        send_idle_pct  = 0;
  int        recv_idle_pct  = 0;
  logic      req_taken      = 1'b0;
  logic      hold_req       = 1'b0;
  logic      hold_ack       = 1'b0;
  int        hold_left      = 0;

  always #5 clk_i = ~clk_i;

  function automatic idx_t held_bytes();
    return idx_t'(wr_ptr - rd_ptr);
  endfunction

  function automatic idx_t space_left();
    return idx_t'(rd_ptr - wr_ptr - 1);
  endfunction

  function automatic logic [PktW-1:0] close_at();
    logic [PktW-1:0] lim;
    lim = pkt_lim;
    if (crlf_on) begin
      lim = (lim > PktW'(2)) ? lim - PktW'(2) : '0;
    end
    return (lim < 1) ? PktW'(1) : lim;
  endfunction

  function automatic logic count_out_byte(logic may_close);
    pkt_bytes = pkt_bytes + 1'b1;
    if (may_close && (pkt_bytes >= close_at() || held_bytes() == 0)) begin
      pkt_bytes = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic result_t ring_predict(byte_req_t r);
    result_t          res;
    logic [ByteW-1:0] b;
    res = '0;
    if (r.mode == MODE_PUT) begin
      // disconnected writer drops old data when the ring runs low
      if (r.start && !link_up && space_left() < low_thr) begin
        wr_ptr = '0;
        rd_ptr = '0;
      end
      if (space_left() != 0) begin
        ring_bytes[wr_ptr] = r.data;
        wr_ptr = wr_ptr + 1'b1;
        res.accepted = 1'b1;
      end
    end else if (lf_owed) begin
      lf_owed = 1'b0;
      res.out_valid = 1'b1;
      res.data_out = CharLf;
      res.packet_last = count_out_byte(1'b1);
    end else if (held_bytes() != 0) begin
      b = ring_bytes[rd_ptr];
      rd_ptr = rd_ptr + 1'b1;
      res.out_valid = 1'b1;
      if (crlf_on && b == CharLf) begin
        res.data_out = CharCr;
        lf_owed = 1'b1;
        res.packet_last = count_out_byte(1'b0);
      end else begin
        res.data_out = b;
        res.packet_last = count_out_byte(1'b1);
      end
    end
    res.fill_level = held_bytes();
    res.free_room = space_left();
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
    end
  endtask

  // request driver, fed from byte_reqs_q
  always @(negedge clk_i) begin : req_driver
    byte_req_t nxt;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      if (byte_reqs_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = byte_reqs_q.pop_front();
        req_if.mode        <= nxt.mode;
        req_if.data_in     <= nxt.data;
        req_if.write_start <= nxt.start;
        req_if.valid       <= 1'b1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : result_sink
    if (hold_left != 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    byte_req_t r;
    result_t   want;
    req_taken = 1'b0;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          REG_LINE_CONNECTED: link_up = cfg_if.data[0];
          REG_LOW_ROOM_THR:   low_thr = cfg_if.data[ThrW-1:0];
          REG_CRLF_ENABLE:    crlf_on = cfg_if.data[0];
          REG_PACKET_LIMIT:   pkt_lim = cfg_if.data[PktW-1:0];
          default: ;
        endcase
      end
      if (req_if.valid && req_if.ready) begin
        req_taken = 1'b1;
        r.mode = req_if.mode;
        r.data = req_if.data_in;
        r.start = req_if.write_start;
        ring_results_q.push_back(ring_predict(r));
        reqs_in_flight--;
      end
      if (res_if.valid && res_if.ready) begin
        if (ring_results_q.size() == 0) begin
          report_mismatch("result with no request outstanding", res_if.data_out, 0);
        end else begin
          want = ring_results_q.pop_front();
          if (res_if.accepted !== want.accepted)
            report_mismatch("accepted", res_if.accepted, want.accepted);
          if (res_if.out_valid !== want.out_valid)
            report_mismatch("out_valid", res_if.out_valid, want.out_valid);
          if (res_if.data_out !== want.data_out)
            report_mismatch("data_out", res_if.data_out, want.data_out);
          if (res_if.packet_last !== want.packet_last)
            report_mismatch("packet_last", res_if.packet_last, want.packet_last);
          if (res_if.fill_level !== want.fill_level)
            report_mismatch("fill_level", res_if.fill_level, want.fill_level);
          if (res_if.free_room !== want.free_room)
            report_mismatch("free_room", res_if.free_room, want.free_room);
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_req(logic mode, logic [ByteW-1:0] data, logic start);
    byte_req_t r;
    r.mode = mode;
    r.data = data;
    r.start = start;
    byte_reqs_q.push_back(r);
    reqs_in_flight++;
  endtask

  task automatic queue_puts(int n, logic rand_data);
    for (int i = 0; i < n; i++) begin
      queue_req(MODE_PUT, rand_data ? ByteW'($urandom_range(255)) : ByteW'(i), i == 0);
    end
  endtask

  task automatic queue_pops(int n);
    for (int i = 0; i < n; i++) begin
      queue_req(MODE_POP, ByteW'($urandom_range(255)), 1'b0);
    end
  endtask

  // sender holds until every request has its result
  task automatic wait_idle();
    do @(negedge clk_i); while (reqs_in_flight != 0 || ring_results_q.size() != 0);
    repeat (3) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(logic link, logic [ThrW-1:0] thr, logic crlf, logic [PktW-1:0] lim);
    write_reg(REG_LINE_CONNECTED, CfgDataW'(link));
    write_reg(REG_LOW_ROOM_THR, CfgDataW'(thr));
    write_reg(REG_CRLF_ENABLE, CfgDataW'(crlf));
    write_reg(REG_PACKET_LIMIT, CfgDataW'(lim));
    @(posedge clk_i);
  endtask

  task automatic random_config();
    logic [ThrW-1:0] thr;
    logic [PktW-1:0] lim;
    case ($urandom_range(4))
      0:       thr = '0;
      1:       thr = ResetThreshold;
      2:       thr = '1;
      default: thr = ThrW'($urandom_range(8151, 8191));
    endcase
    case ($urandom_range(4))
      0:       lim = PktW'(3);
      1:       lim = ResetLimit;
      2:       lim = PktW'($urandom_range(3, 8192));
      default: lim = PktW'($urandom_range(4, 24));
    endcase
    set_config(1'($urandom_range(1)), thr, 1'($urandom_range(1)), lim);
  endtask

  // mostly write bursts and pop bursts, some noise and broken writes
  task automatic queue_random(int n);
    int               k;
    int               len;
    logic [ByteW-1:0] d;
    k = 0;
    while (k < n) begin
      len = 1;
      case ($urandom_range(9))
        0, 1, 2, 3, 4: begin
          len = $urandom_range(1, 16);
          for (int i = 0; i < len; i++) begin
            d = ($urandom_range(3) == 0) ? CharLf : ByteW'($urandom_range(255));
            queue_req(MODE_PUT, d, i == 0);
          end
        end
        5, 6, 7: begin
          len = $urandom_range(1, 18);
          queue_pops(len);
        end
        8: begin
          queue_req(1'($urandom_range(1)), ByteW'($urandom_range(255)), 1'($urandom_range(1)));
        end
        default: begin
          len = $urandom_range(2, 8);
          for (int i = 0; i < len; i++) begin
            d = ($urandom_range(2) == 0) ? CharLf : ByteW'($urandom_range(255));
            queue_req(MODE_PUT, d, 1'($urandom_range(1)));
          end
        end
      endcase
      k += len;
    end
  endtask

  initial begin : stimulus
    req_if.valid       = 1'b0;
    req_if.mode        = MODE_PUT;
    req_if.data_in     = '0;
    req_if.write_start = 1'b0;
    res_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_LINE_CONNECTED;
    cfg_if.data        = '0;
    wr_ptr    = '0;
    rd_ptr    = '0;
    lf_owed   = 1'b0;
    pkt_bytes = '0;
    link_up   = 1'b1;
    low_thr   = ResetThreshold;
    crlf_on   = 1'b1;
    pkt_lim   = ResetLimit;
    send_idle_pct = 12;
    recv_idle_pct = 56;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pop on empty, byte extremes, lf expansion, close on empty
    queue_pops(1);
    queue_req(MODE_PUT, 8'h00, 1'b1);
    queue_req(MODE_PUT, 8'hFF, 1'b0);
    queue_req(MODE_PUT, CharLf, 1'b0);
    queue_req(MODE_PUT, CharCr, 1'b0);
    queue_req(MODE_PUT, 8'h41, 1'b0);
    queue_pops(7);
    // lf still owed after expansion is switched off
    queue_req(MODE_PUT, CharLf, 1'b1);
    queue_pops(1);
    wait_idle();
    write_reg(REG_CRLF_ENABLE, '0);
    @(posedge clk_i);
    queue_pops(1);
    queue_req(MODE_PUT, CharLf, 1'b1);
    queue_pops(1);
    // emptying while an lf is owed, smallest packet limit
    wait_idle();
    set_config(1'b0, '1, 1'b1, PktW'(3));
    queue_req(MODE_PUT, CharLf, 1'b1);
    queue_req(MODE_PUT, 8'h55, 1'b0);
    queue_pops(1);
    queue_req(MODE_PUT, 8'h66, 1'b1);
    queue_pops(2);
    // limit lowered in the middle of a packet
    wait_idle();
    set_config(1'b1, ResetThreshold, 1'b1, ResetLimit);
    queue_puts(3, 1'b1);
    queue_pops(1);
    wait_idle();
    write_reg(REG_PACKET_LIMIT, CfgDataW'(3));
    @(posedge clk_i);
    queue_pops(2);

    // full ring with index wrap, refusals, then overwrite thresholds
    wait_idle();
    set_config(1'b1, ResetThreshold, 1'b1, PktW'(5));
    queue_puts(100, 1'b1);
    queue_pops(100);
    queue_puts(RingDepth - 1, 1'b1);
    queue_req(MODE_PUT, 8'hA5, 1'b1);
    queue_req(MODE_PUT, 8'h5A, 1'b0);
    queue_pops(5);
    queue_puts(6, 1'b1);
    wait_idle();
    set_config(1'b0, '0, 1'b1, ResetLimit);
    queue_req(MODE_PUT, 8'h77, 1'b1);
    wait_idle();
    write_reg(REG_LOW_ROOM_THR, CfgDataW'(1));
    @(posedge clk_i);
    queue_req(MODE_PUT, 8'h77, 1'b1);
    queue_pops(3);
    wait_idle();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int seg = 0; seg < SEGS_PER_PHASE; seg++) begin
        random_config();
        if (ph == 0 && seg == 1) begin
          // receiver stalls long while requests keep coming
          queue_random(40);
          hold_req = ~hold_req;
        end
        queue_random(SEG_ITEMS);
        wait_idle();
      end
    end

    repeat (10) @(negedge clk_i);
    if (ring_results_q.size() != 0) begin
      report_mismatch("results never delivered", 0, ring_results_q.size());
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== console_ring_crlf_packetizer.f =====
hdl/crcp_pkg.sv
hdl/crcp_if.sv
hdl/crcp_ring_mem.sv
hdl/console_ring_crlf_packetizer.sv
dv/tb.sv
